// ===== hw/rtl/keyboard_scan_layer_report_macros.svh =====
// Assertion macros shared by the keyboard scan checkers
`ifndef KEYBOARD_SCAN_LAYER_REPORT_MACROS_SVH
`define KEYBOARD_SCAN_LAYER_REPORT_MACROS_SVH

// same-cycle implication, held off during reset
`define KSLR_CHECK_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define KSLR_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define KSLR_CHECK_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kslr_pkg.sv =====
// Shared types, constants and width helpers for the keyboard scan block
package kslr_pkg;

    localparam int DEF_NUM_KEYS     = 64;
    localparam int DEF_NUM_LAYERS   = 4;
    localparam int DEF_REPORT_SLOTS = 6;
    localparam int MAX_SLOTS        = 6;
    localparam int BASE_LAYER       = 1;

    localparam int KEY_FIELD_W   = 6;
    localparam int LAYER_FIELD_W = 3;
    localparam int KIND_W        = 2;
    localparam int CODE_W        = 8;
    localparam int HIST_W        = 8;
    localparam int KEY_CMP_W     = 9;   // holds NUM_KEYS up to 511
    localparam int LAYER_CMP_W   = 4;   // holds NUM_LAYERS up to 15

    localparam logic [HIST_W-1:0] DEBOUNCE_RESET = 8'd15;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 2'd0,
        KIND_GENERAL  = 2'd1,
        KIND_MODIFIER = 2'd2,
        KIND_LAYER    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] code;
    } t_entry;

    // key-state stage towards the keymap stage
    typedef struct packed {
        logic   valid;
        logic   map_we;
        logic   apply;
        logic   scan_end;
        t_entry wentry;
    } t_s1;

    // keymap stage towards the report builder
    typedef struct packed {
        logic   valid;
        logic   apply;
        logic   scan_end;
        t_entry entry;
    } t_s2;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== hw/rtl/keyboard_scan_layer_report.sv =====
// Top level of the keyboard scan, debounce, layered keymap and report block
// Takes one item per clock: a keymap write or one key's raw sample, with
// the keys of a scan arriving in ascending order and the last one flagged.
// Each sample goes through a three-step pipeline: the key's history and
// latched layer are read from the key-state memory at acceptance, shifted,
// debounced against the mask and written back from the key-state stage (the
// last write-back is forwarded when the same key follows directly); the
// keymap memory is next read for the latched layer, and the effect is
// then folded into the pending report. The last sample of a scan loads
// the report into the output register as it leaves the keymap stage and
// commits the new active layer, which is forwarded to a key latching in
// the same cycle. Input stalls only while a finished report is waiting in
// the output register and the next report is ready behind it; otherwise the
// block keeps taking items while the report waits. The key-state memory
// comes out of reset cleared through one valid bit per key, so there is no
// clearing pass; the keymap holds no reset value and every entry that a
// pressed key can reach has to be written before the first scan.
module keyboard_scan_layer_report #(
    parameter int NUM_KEYS     = kslr_pkg::DEF_NUM_KEYS,
    parameter int NUM_LAYERS   = kslr_pkg::DEF_NUM_LAYERS,
    parameter int REPORT_SLOTS = kslr_pkg::DEF_REPORT_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // debounce mask register
    input  logic                                i_cfg_wr_en,
    input  logic [kslr_pkg::HIST_W-1:0]         i_cfg_wr_data,
    // item input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [kslr_pkg::KEY_FIELD_W-1:0]    i_key_index,
    input  logic                                i_key_down,
    input  logic                                i_scan_end,
    input  logic [kslr_pkg::LAYER_FIELD_W-1:0]  i_map_layer,
    input  logic [kslr_pkg::KIND_W-1:0]         i_map_kind,
    input  logic [kslr_pkg::CODE_W-1:0]         i_map_code,
    // report output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [kslr_pkg::CODE_W-1:0]         o_modifier_bits,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_zero,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_one,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_two,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_three,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_four,
    output logic [kslr_pkg::CODE_W-1:0]         o_slot_five,
    output logic [kslr_pkg::LAYER_FIELD_W-1:0]  o_current_layer
);
    import kslr_pkg::*;

    localparam int KEY_AW  = idx_w(NUM_KEYS);
    localparam int LAYER_W = idx_w(NUM_LAYERS + 1);

    logic [HIST_W-1:0]                r_debounce_mask;
    logic                             adv;
    logic                             take;
    logic                             busy;
    t_s1                              s1;
    t_s2                              s2;
    logic [KEY_AW-1:0]                s1_key;
    logic [LAYER_W-1:0]               s1_layer;
    logic [LAYER_W-1:0]               active_fwd;
    logic [MAX_SLOTS-1:0][CODE_W-1:0] slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_mask <= DEBOUNCE_RESET;
        end else if (i_cfg_wr_en) begin
            r_debounce_mask <= i_cfg_wr_data;
        end
    end

    // whole pipeline holds only when a report cannot enter the output register
    assign adv     = !busy;
    assign o_stall = !adv;
    assign take    = i_valid && adv;

    kslr_keystate #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_keystate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_take      (take),
        .i_req_type  (i_req_type),
        .i_key_index (i_key_index),
        .i_key_down  (i_key_down),
        .i_scan_end  (i_scan_end),
        .i_map_layer (i_map_layer),
        .i_map_kind  (i_map_kind),
        .i_map_code  (i_map_code),
        .i_mask      (r_debounce_mask),
        .i_active    (active_fwd),
        .o_s1        (s1),
        .o_key       (s1_key),
        .o_layer     (s1_layer)
    );

    kslr_keymap #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_keymap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_s1    (s1),
        .i_key   (s1_key),
        .i_layer (s1_layer),
        .o_s2    (s2)
    );

    kslr_report #(
        .NUM_LAYERS   (NUM_LAYERS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_report (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_s2            (s2),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_busy          (busy),
        .o_active        (active_fwd),
        .o_modifier_bits (o_modifier_bits),
        .o_slots         (slots),
        .o_current_layer (o_current_layer)
    );

    assign o_slot_zero  = slots[0];
    assign o_slot_one   = slots[1];
    assign o_slot_two   = slots[2];
    assign o_slot_three = slots[3];
    assign o_slot_four  = slots[4];
    assign o_slot_five  = slots[5];

endmodule

// ===== hw/rtl/kslr_keystate.sv =====
// Per-key history and latched layer memory with debounce read-modify-write
module kslr_keystate #(
    parameter int NUM_KEYS   = kslr_pkg::DEF_NUM_KEYS,
    parameter int NUM_LAYERS = kslr_pkg::DEF_NUM_LAYERS
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  logic                                            i_take,
    input  logic                                            i_req_type,
    input  logic [kslr_pkg::KEY_FIELD_W-1:0]                i_key_index,
    input  logic                                            i_key_down,
    input  logic                                            i_scan_end,
    input  logic [kslr_pkg::LAYER_FIELD_W-1:0]              i_map_layer,
    input  logic [kslr_pkg::KIND_W-1:0]                     i_map_kind,
    input  logic [kslr_pkg::CODE_W-1:0]                     i_map_code,
    input  logic [kslr_pkg::HIST_W-1:0]                     i_mask,
    input  logic [kslr_pkg::idx_w(NUM_LAYERS + 1)-1:0]      i_active,
    output kslr_pkg::t_s1                                   o_s1,
    output logic [kslr_pkg::idx_w(NUM_KEYS)-1:0]            o_key,
    output logic [kslr_pkg::idx_w(NUM_LAYERS + 1)-1:0]      o_layer
);
    import kslr_pkg::*;

    localparam int KEY_AW  = idx_w(NUM_KEYS);
    localparam int LAYER_W = idx_w(NUM_LAYERS + 1);
    localparam int ST_W    = HIST_W + LAYER_W;

    logic [ST_W-1:0]        mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]    r_kvalid;

    logic                   r_valid;
    logic                   r_sample;
    logic [KEY_AW-1:0]      r_key;
    logic                   r_down;
    logic                   r_end;
    logic                   r_key_ok;
    logic                   r_map_ok;
    logic [LAYER_W-1:0]     r_map_layer;
    t_entry                 r_wentry;
    logic [ST_W-1:0]        r_rd_data;
    logic                   r_rd_vld;
    logic                   r_wb_valid;
    logic [KEY_AW-1:0]      r_wb_key;
    logic [ST_W-1:0]        r_wb_data;

    logic [KEY_CMP_W-1:0]   key_ext;
    logic [KEY_AW-1:0]      key_idx;
    logic                   key_ok;
    logic [LAYER_CMP_W-1:0] ml_ext;
    logic                   map_ok;
    logic                   fwd;
    logic [ST_W-1:0]        cur;
    logic [HIST_W-1:0]      cur_hist;
    logic [LAYER_W-1:0]     cur_lat;
    logic [HIST_W-1:0]      hist;
    logic                   all_set;
    logic                   all_clr;
    logic [LAYER_W-1:0]     n_lat;
    logic [ST_W-1:0]        n_state;
    logic                   st_we;

    assign key_ext = KEY_CMP_W'(i_key_index);
    assign key_idx = key_ext[KEY_AW-1:0];
    assign key_ok  = key_ext < KEY_CMP_W'(NUM_KEYS);
    assign ml_ext  = LAYER_CMP_W'(i_map_layer);
    assign map_ok  = (i_req_type == REQ_WRITE) && (ml_ext != '0)
                     && (ml_ext <= LAYER_CMP_W'(NUM_LAYERS)) && key_ok;

    // last write-back lands on the edge the current read was issued
    assign fwd      = r_wb_valid && (r_wb_key == r_key);
    assign cur      = fwd ? r_wb_data : (r_rd_vld ? r_rd_data : '0);
    assign cur_hist = cur[ST_W-1:LAYER_W];
    assign cur_lat  = cur[LAYER_W-1:0];
    assign hist     = {cur_hist[HIST_W-2:0], r_down};
    assign all_set  = (hist & i_mask) == i_mask;
    assign all_clr  = (hist & i_mask) == '0;

    always_comb begin
        if (cur_lat == '0) begin
            n_lat = all_set ? i_active : '0;
        end else begin
            n_lat = all_clr ? '0 : cur_lat;
        end
    end

    assign n_state = {hist, n_lat};
    assign st_we   = i_adv && r_valid && r_sample && r_key_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_wb_valid <= 1'b0;
            r_kvalid   <= '0;
        end else if (i_adv) begin
            r_valid    <= i_take;
            r_wb_valid <= st_we;
            if (st_we) begin
                r_kvalid[r_key] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem[r_key] <= n_state;
        end
        if (i_take) begin
            r_rd_data <= mem[key_idx];
            r_rd_vld  <= r_kvalid[key_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wb_key  <= r_key;
            r_wb_data <= n_state;
        end
        if (i_take) begin
            r_sample         <= (i_req_type == REQ_SAMPLE);
            r_key            <= key_idx;
            r_down           <= i_key_down;
            r_end            <= i_scan_end;
            r_key_ok         <= key_ok;
            r_map_ok         <= map_ok;
            r_map_layer      <= ml_ext[LAYER_W-1:0];
            r_wentry.kind    <= t_kind'(i_map_kind);
            r_wentry.code    <= i_map_code;
        end
    end

    always_comb begin
        o_s1.valid    = r_valid;
        o_s1.map_we   = r_valid && !r_sample && r_map_ok;
        o_s1.apply    = r_valid && r_sample && r_key_ok && (n_lat != '0);
        o_s1.scan_end = r_valid && r_sample && r_end;
        o_s1.wentry   = r_wentry;
    end

    assign o_key   = r_key;
    assign o_layer = r_sample ? n_lat : r_map_layer;

endmodule

// ===== hw/rtl/kslr_keymap.sv =====
// Layered keymap memory: entry writes and per-key effect lookup
module kslr_keymap #(
    parameter int NUM_KEYS   = kslr_pkg::DEF_NUM_KEYS,
    parameter int NUM_LAYERS = kslr_pkg::DEF_NUM_LAYERS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_adv,
    input  kslr_pkg::t_s1                              i_s1,
    input  logic [kslr_pkg::idx_w(NUM_KEYS)-1:0]       i_key,
    input  logic [kslr_pkg::idx_w(NUM_LAYERS + 1)-1:0] i_layer,
    output kslr_pkg::t_s2                              o_s2
);
    import kslr_pkg::*;

    localparam int KEY_AW    = idx_w(NUM_KEYS);
    localparam int LAYER_W   = idx_w(NUM_LAYERS + 1);
    localparam int MAP_DEPTH = NUM_KEYS * NUM_LAYERS;
    localparam int MAP_AW    = idx_w(MAP_DEPTH);

    t_entry             mem [MAP_DEPTH];
    t_entry             r_rdata;
    logic               r_valid;
    logic               r_apply;
    logic               r_end;

    logic [LAYER_W-1:0] lay_m1;
    logic [MAP_AW-1:0]  addr;

    // row per layer, layer one first
    assign lay_m1 = i_layer - LAYER_W'(BASE_LAYER);
    assign addr   = MAP_AW'(lay_m1 * NUM_KEYS) + MAP_AW'(i_key);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_s1.map_we) begin
                mem[addr] <= i_s1.wentry;
            end
            if (i_s1.apply) begin
                r_rdata <= mem[addr];
            end
            r_apply <= i_s1.apply;
            r_end   <= i_s1.scan_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_s1.valid;
        end
    end

    always_comb begin
        o_s2.valid    = r_valid;
        o_s2.apply    = r_valid && r_apply;
        o_s2.scan_end = r_valid && r_end;
        o_s2.entry    = r_rdata;
    end

endmodule

// ===== hw/rtl/kslr_report.sv =====
// Report accumulation, layer commit and output register
module kslr_report #(
    parameter int NUM_LAYERS   = kslr_pkg::DEF_NUM_LAYERS,
    parameter int REPORT_SLOTS = kslr_pkg::DEF_REPORT_SLOTS
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_adv,
    input  kslr_pkg::t_s2                                           i_s2,
    input  logic                                                    i_stall,
    output logic                                                    o_valid,
    output logic                                                    o_busy,
    output logic [kslr_pkg::idx_w(NUM_LAYERS + 1)-1:0]              o_active,
    output logic [kslr_pkg::CODE_W-1:0]                             o_modifier_bits,
    output logic [kslr_pkg::MAX_SLOTS-1:0][kslr_pkg::CODE_W-1:0]    o_slots,
    output logic [kslr_pkg::LAYER_FIELD_W-1:0]                      o_current_layer
);
    import kslr_pkg::*;

    localparam int LAYER_W = idx_w(NUM_LAYERS + 1);
    localparam int CNT_W   = $clog2(REPORT_SLOTS + 1);

    logic [LAYER_W-1:0]     r_level;
    logic [CODE_W-1:0]      r_mods;
    logic [CODE_W-1:0]      r_slots [REPORT_SLOTS];
    logic [CNT_W-1:0]       r_count;
    logic [LAYER_W-1:0]     r_active;
    logic                   r_out_valid;
    logic [CODE_W-1:0]      r_out_mods;
    logic [CODE_W-1:0]      r_out_slots [REPORT_SLOTS];
    logic [LAYER_W-1:0]     r_out_layer;

    logic [LAYER_W-1:0]     n_level;
    logic [CODE_W-1:0]      n_mods;
    logic [CODE_W-1:0]      n_slots [REPORT_SLOTS];
    logic [CNT_W-1:0]       n_count;
    logic                   report_load;
    logic [LAYER_CMP_W-1:0] out_layer_ext;

    always_comb begin
        n_level = r_level;
        n_mods  = r_mods;
        n_slots = r_slots;
        n_count = r_count;
        if (i_s2.apply) begin
            case (i_s2.entry.kind)
                KIND_GENERAL: begin
                    // slots fill in key order, extra codes dropped
                    if (r_count < CNT_W'(REPORT_SLOTS)) begin
                        for (int k = 0; k < REPORT_SLOTS; k++) begin
                            if (r_count == CNT_W'(k)) begin
                                n_slots[k] = i_s2.entry.code;
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                KIND_MODIFIER: begin
                    n_mods = r_mods | i_s2.entry.code;
                end
                KIND_LAYER: begin
                    // out-of-range layers and layers not above the current one are ignored
                    if ((i_s2.entry.code <= CODE_W'(NUM_LAYERS))
                        && (i_s2.entry.code > CODE_W'(r_level))) begin
                        n_level = LAYER_W'(i_s2.entry.code);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign report_load = i_adv && i_s2.valid && i_s2.scan_end;
    assign o_busy      = i_s2.valid && i_s2.scan_end && r_out_valid && i_stall;
    // a scan end one stage ahead commits before the next key latches
    assign o_active    = (i_s2.valid && i_s2.scan_end) ? n_level : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LAYER_W'(BASE_LAYER);
            r_mods      <= '0;
            r_count     <= '0;
            r_active    <= LAYER_W'(BASE_LAYER);
            r_out_valid <= 1'b0;
            for (int k = 0; k < REPORT_SLOTS; k++) begin
                r_slots[k] <= '0;
            end
        end else begin
            if (i_adv && i_s2.valid) begin
                if (i_s2.scan_end) begin
                    r_level  <= LAYER_W'(BASE_LAYER);
                    r_mods   <= '0;
                    r_count  <= '0;
                    r_active <= n_level;
                    for (int k = 0; k < REPORT_SLOTS; k++) begin
                        r_slots[k] <= '0;
                    end
                end else begin
                    r_level <= n_level;
                    r_mods  <= n_mods;
                    r_count <= n_count;
                    r_slots <= n_slots;
                end
            end
            r_out_valid <= report_load || (r_out_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (report_load) begin
            r_out_mods  <= n_mods;
            r_out_slots <= n_slots;
            r_out_layer <= n_level;
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_SLOTS; j++) begin : g_slot
            if (j < REPORT_SLOTS) begin : g_used
                assign o_slots[j] = r_out_slots[j];
            end else begin : g_empty
                assign o_slots[j] = '0;
            end
        end
    endgenerate

    assign out_layer_ext   = LAYER_CMP_W'(r_out_layer);
    assign o_valid         = r_out_valid;
    assign o_modifier_bits = r_out_mods;
    assign o_current_layer = out_layer_ext[LAYER_FIELD_W-1:0];

endmodule

// ===== hw/rtl/kslr_checker.sv =====
// Port-level checks for the keyboard scan block, bound to the top level
`include "keyboard_scan_layer_report_macros.svh"

module kslr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_modifier_bits,
    input logic [7:0] o_slot_zero,
    input logic [2:0] o_current_layer
);

    `KSLR_CHECK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_modifier_bits) && $stable(o_slot_zero) && $stable(o_current_layer), "report changed while stalled")
    `KSLR_CHECK_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked report")
    `KSLR_CHECK_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_stall, "report pending straight after reset")
    `KSLR_CHECK_NEXT(a_no_drop, i_clk, i_rst_n, o_valid && i_stall, o_valid, "report lost while stalled")
    `KSLR_CHECK_NOW(a_layer_nonzero, i_clk, i_rst_n, o_valid && i_valid, o_current_layer != 3'd0, "report carries layer zero")

endmodule

bind keyboard_scan_layer_report kslr_checker u_kslr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_modifier_bits (o_modifier_bits),
    .o_slot_zero     (o_slot_zero),
    .o_current_layer (o_current_layer)
);

// ===== sim/tb_keyboard_scan_layer_report.sv =====
// Self-checking testbench for the keyboard scan, debounce, layered keymap and report block
module tb_keyboard_scan_layer_report;
    timeunit 1ns;
    timeprecision 1ps;

    import kslr_pkg::*;

    // Block configuration as instantiated
    localparam int NUM_KEYS     = DEF_NUM_KEYS;
    localparam int NUM_LAYERS   = DEF_NUM_LAYERS;
    localparam int REPORT_SLOTS = DEF_REPORT_SLOTS;
    localparam int KEYMAP_DEPTH = NUM_KEYS * NUM_LAYERS;

    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;   // long output hold-off for the back-pressure test
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with nothing accepted on either side
    localparam int PRINT_LIMIT     = 40;

    // One input item, every field as the ports carry it
    typedef struct {
        t_req                     req;
        logic [KEY_FIELD_W-1:0]   key;
        logic                     down;
        logic                     last;
        logic [LAYER_FIELD_W-1:0] layer;
        logic [KIND_W-1:0]        kind;
        logic [CODE_W-1:0]        code;
    } t_kbd_item;

    // One HID-style report as the block emits it
    typedef struct packed {
        logic [CODE_W-1:0]                mods;
        logic [MAX_SLOTS-1:0][CODE_W-1:0] slots;
        logic [LAYER_FIELD_W-1:0]         layer;
    } t_hid_report;

    // ---------------------------------------------------------------
    // Ports; every input is known from time zero
    // ---------------------------------------------------------------
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [HIST_W-1:0]        i_cfg_wr_data = '0;
    logic                     i_valid       = 1'b0;
    logic                     o_stall;
    logic                     i_req_type    = 1'b0;
    logic [KEY_FIELD_W-1:0]   i_key_index   = '0;
    logic                     i_key_down    = 1'b0;
    logic                     i_scan_end    = 1'b0;
    logic [LAYER_FIELD_W-1:0] i_map_layer   = '0;
    logic [KIND_W-1:0]        i_map_kind    = '0;
    logic [CODE_W-1:0]        i_map_code    = '0;
    logic                     o_valid;
    logic                     i_stall       = 1'b0;
    logic [CODE_W-1:0]        o_modifier_bits;
    logic [CODE_W-1:0]        o_slot_zero;
    logic [CODE_W-1:0]        o_slot_one;
    logic [CODE_W-1:0]        o_slot_two;
    logic [CODE_W-1:0]        o_slot_three;
    logic [CODE_W-1:0]        o_slot_four;
    logic [CODE_W-1:0]        o_slot_five;
    logic [LAYER_FIELD_W-1:0] o_current_layer;

    keyboard_scan_layer_report #(
        .NUM_KEYS     (NUM_KEYS),
        .NUM_LAYERS   (NUM_LAYERS),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_key_index     (i_key_index),
        .i_key_down      (i_key_down),
        .i_scan_end      (i_scan_end),
        .i_map_layer     (i_map_layer),
        .i_map_kind      (i_map_kind),
        .i_map_code      (i_map_code),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_modifier_bits (o_modifier_bits),
        .o_slot_zero     (o_slot_zero),
        .o_slot_one      (o_slot_one),
        .o_slot_two      (o_slot_two),
        .o_slot_three    (o_slot_three),
        .o_slot_four     (o_slot_four),
        .o_slot_five     (o_slot_five),
        .o_current_layer (o_current_layer)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow of the block: key state, keymap, pending report
    // ---------------------------------------------------------------
    logic [HIST_W-1:0]        key_hist  [NUM_KEYS];
    logic [LAYER_FIELD_W-1:0] key_latch [NUM_KEYS];   // 0 = released
    t_entry                   keymap    [KEYMAP_DEPTH];
    logic [LAYER_FIELD_W-1:0] live_layer;             // committed at the previous scan end
    logic [LAYER_FIELD_W-1:0] next_layer;
    logic [CODE_W-1:0]        next_mods;
    logic [MAX_SLOTS-1:0][CODE_W-1:0] next_slots;
    int                       slot_fill;
    logic [HIST_W-1:0]        mask_copy;

    t_hid_report due_reports [$];

    // physical key positions that the well-formed scans sample
    logic key_phys [NUM_KEYS];

    int err_count       = 0;
    int items_sent      = 0;
    int reports_checked = 0;
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    logic rx_hold_armed = 1'b0;

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_hist[k]  = '0;
            key_latch[k] = '0;
            key_phys[k]  = 1'b0;
        end
        live_layer = LAYER_FIELD_W'(BASE_LAYER);
        next_layer = LAYER_FIELD_W'(BASE_LAYER);
        next_mods  = '0;
        next_slots = '0;
        slot_fill  = 0;
        mask_copy  = DEBOUNCE_RESET;
    end

    // Work out what one accepted item does; a scan end queues its report
    function automatic void predict_report(input t_kbd_item it);
        logic [HIST_W-1:0] hist;
        t_entry            ent;
        t_hid_report       rep;
        int                k;
        if (it.req == REQ_WRITE) begin
            // writes outside layers 1..NUM_LAYERS are dropped
            if (it.layer >= 1 && it.layer <= NUM_LAYERS)
                keymap[(int'(it.layer) - 1) * NUM_KEYS + int'(it.key)] = {it.kind, it.code};
        end else begin
            k = int'(it.key);
            hist = {key_hist[k][HIST_W-2:0], it.down};
            key_hist[k] = hist;
            if (key_latch[k] == 0) begin
                if ((hist & mask_copy) == mask_copy)
                    key_latch[k] = live_layer;
            end else if ((hist & mask_copy) == 0) begin
                key_latch[k] = '0;
            end
            if (key_latch[k] != 0) begin
                ent = keymap[(int'(key_latch[k]) - 1) * NUM_KEYS + k];
                case (ent.kind)
                    KIND_GENERAL: begin
                        // beyond the last slot general codes are lost
                        if (slot_fill < REPORT_SLOTS) begin
                            next_slots[slot_fill] = ent.code;
                            slot_fill++;
                        end
                    end
                    KIND_MODIFIER: next_mods = next_mods | ent.code;
                    KIND_LAYER: begin
                        // layer 0, layers past the top and any not above next_layer are not taken
                        if (ent.code <= NUM_LAYERS && ent.code > next_layer)
                            next_layer = ent.code[LAYER_FIELD_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (it.last) begin
                rep.mods  = next_mods;
                rep.slots = next_slots;
                rep.layer = next_layer;
                due_reports.push_back(rep);
                live_layer = next_layer;
                next_layer = LAYER_FIELD_W'(BASE_LAYER);
                next_mods  = '0;
                next_slots = '0;
                slot_fill  = 0;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Item builders; fields the block ignores carry random values
    // ---------------------------------------------------------------
    function automatic t_kbd_item sample_of(input int key, input bit down, input bit last);
        t_kbd_item it;
        it.req   = REQ_SAMPLE;
        it.key   = key[KEY_FIELD_W-1:0];
        it.down  = down;
        it.last  = last;
        it.layer = LAYER_FIELD_W'($urandom_range(7));
        it.kind  = KIND_W'($urandom_range(3));
        it.code  = CODE_W'($urandom_range(255));
        return it;
    endfunction

    function automatic t_kbd_item write_of(input int layer, input int key,
                                           input t_kind kind, input int code);
        t_kbd_item it;
        it.req   = REQ_WRITE;
        it.key   = key[KEY_FIELD_W-1:0];
        it.down  = 1'($urandom_range(1));
        it.last  = 1'($urandom_range(1));
        it.layer = layer[LAYER_FIELD_W-1:0];
        it.kind  = kind;
        it.code  = code[CODE_W-1:0];
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Sender: random gap, then hold the item until accepted
    // ---------------------------------------------------------------
    task automatic send_item(input t_kbd_item it);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= it.req;
        i_key_index <= it.key;
        i_key_down  <= it.down;
        i_scan_end  <= it.last;
        i_map_layer <= it.layer;
        i_map_kind  <= it.kind;
        i_map_code  <= it.code;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_report(it);
        items_sent++;
    endtask

    // Drop valid, wait for every due report, then let the pipeline empty
    task automatic settle_block();
        i_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce_mask(input logic [HIST_W-1:0] mask);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mask;
        @(posedge i_clk);
        mask_copy = mask;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d (report %0d)",
                     $realtime, what, got, want, reports_checked);
    endtask

    // ---------------------------------------------------------------
    // Traffic: mostly ascending scans over a small pool of held keys,
    // so that histories debounce; some keymap writes, some broken scans
    // ---------------------------------------------------------------
    task automatic send_random_traffic(input int n_items);
        logic [NUM_KEYS-1:0] pool;
        logic [NUM_KEYS-1:0] picked;
        int                  sent;
        int                  r;
        int                  n;
        int                  last_key;
        int                  layer;
        t_kind               kind;
        int                  code;
        bit                  down;
        pool = '0;
        while ($countones(pool) < 10)
            pool[$urandom_range(NUM_KEYS - 1)] = 1'b1;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 12) begin
                // keymap rewrite, now and then to a layer the block drops
                layer = ($urandom_range(3) != 0) ? $urandom_range(1, NUM_LAYERS)
                                                 : $urandom_range(7);
                kind  = t_kind'($urandom_range(3));
                code  = (kind == KIND_LAYER && $urandom_range(9) < 7) ? $urandom_range(6)
                                                                    : $urandom_range(255);
                send_item(write_of(layer, $urandom_range(NUM_KEYS - 1), kind, code));
                sent++;
            end else if (r < 20) begin
                // out-of-order or repeated keys, scan end not always given
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    send_item(sample_of($urandom_range(NUM_KEYS - 1), 1'($urandom_range(1)),
                                        (i == n - 1) && ($urandom_range(3) != 0)));
                    sent++;
                end
            end else begin
                picked = '0;
                for (int k = 0; k < NUM_KEYS; k++)
                    if (pool[k] && $urandom_range(9) != 0)
                        picked[k] = 1'b1;
                if (picked == 0)
                    picked = pool;
                last_key = 0;
                for (int k = 0; k < NUM_KEYS; k++)
                    if (picked[k])
                        last_key = k;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (picked[k]) begin
                        if ($urandom_range(99) < 8)
                            key_phys[k] = ~key_phys[k];
                        down = key_phys[k] ^ ($urandom_range(99) < 5);   // contact bounce
                        send_item(sample_of(k, down, k == last_key));
                        sent++;
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill every keymap entry before any key can latch. Layer 1 is laid out
    // by hand for the directed cases; the upper layers get random content.
    task automatic test_keymap_load();
        t_kind kind;
        int    code;
        for (int lay = 1; lay <= NUM_LAYERS; lay++) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (lay == 1) begin
                    if (k < 32) begin
                        kind = KIND_GENERAL;
                        code = 8 * k + 7;
                    end else if (k < 48) begin
                        kind = KIND_MODIFIER;
                        code = 1 << (k % 8);
                    end else if (k < 56) begin
                        kind = KIND_LAYER;
                        code = k - 48;          // 0..7, half of them out of range
                    end else begin
                        kind = KIND_NONE;
                        code = $urandom_range(255);
                    end
                end else begin
                    kind = t_kind'($urandom_range(3));
                    code = (kind == KIND_LAYER) ? $urandom_range(7) : $urandom_range(255);
                end
                send_item(write_of(lay, k, kind, code));
            end
        end
    endtask

    // Hand-picked scans with a one-sample debounce, then a zero mask
    task automatic test_directed_cases();
        write_debounce_mask(8'h01);
        // seven general keys fill the six slots, two modifiers, layer key to the top layer
        for (int k = 0; k < 7; k++)
            send_item(sample_of(k, 1'b1, 1'b0));
        send_item(sample_of(32, 1'b1, 1'b0));
        send_item(sample_of(39, 1'b1, 1'b0));
        send_item(sample_of(52, 1'b1, 1'b1));
        // release, layer codes 0/5/7 ignored, key 1 left out, key 55 sampled twice
        send_item(sample_of(0, 1'b0, 1'b0));
        send_item(sample_of(48, 1'b1, 1'b0));
        send_item(sample_of(53, 1'b1, 1'b0));
        send_item(sample_of(55, 1'b1, 1'b0));
        send_item(sample_of(55, 1'b1, 1'b1));
        // writes to layer 0 and above the top are dropped; code extremes
        send_item(write_of(0, 63, KIND_GENERAL, 8'hAA));
        send_item(write_of(5, 0, KIND_MODIFIER, 8'h55));
        send_item(write_of(7, 63, KIND_LAYER, 8'hFF));
        send_item(write_of(NUM_LAYERS, 63, KIND_GENERAL, 8'h00));
        send_item(write_of(1, 62, KIND_MODIFIER, 8'hFF));
        // zero mask: a released key latches at once, a latched one lets go
        write_debounce_mask(8'h00);
        send_item(sample_of(62, 1'b0, 1'b0));
        send_item(sample_of(2, 1'b1, 1'b0));
        send_item(sample_of(63, 1'b1, 1'b1));
    endtask

    task automatic test_random_phase(input logic [HIST_W-1:0] mask, input int n_items);
        write_debounce_mask(mask);
        send_random_traffic(n_items);
    endtask

    // Output held off for a long stretch while items keep coming
    task automatic test_backpressure();
        settle_block();
        rx_hold_armed <= 1'b1;
        send_random_traffic(80);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall, or a long hold-off once armed
    // ---------------------------------------------------------------
    logic hold_armed_q = 1'b0;
    int   hold_left    = 0;

    always @(posedge i_clk) begin
        hold_armed_q <= rx_hold_armed;
        if (rx_hold_armed && !hold_armed_q) begin
            hold_left <= HOLD_OFF_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Report checker: each accepted report against the oldest one due
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_reports
        t_hid_report want;
        logic [MAX_SLOTS-1:0][CODE_W-1:0] got_slots;
        if (i_rst_n && o_valid && !i_stall) begin
            got_slots = {o_slot_five, o_slot_four, o_slot_three,
                         o_slot_two, o_slot_one, o_slot_zero};
            if (due_reports.size() == 0) begin
                report_mismatch("report with none due", 1, 0);
            end else begin
                want = due_reports.pop_front();
                if (o_modifier_bits !== want.mods)
                    report_mismatch("modifier_bits", o_modifier_bits, want.mods);
                for (int j = 0; j < MAX_SLOTS; j++)
                    if (got_slots[j] !== want.slots[j])
                        report_mismatch($sformatf("slot %0d", j), got_slots[j], want.slots[j]);
                if (o_current_layer !== want.layer)
                    report_mismatch("current_layer", o_current_layer, want.layer);
            end
            reports_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long with nothing accepted on either side
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item accepted for %0d cycles, %0d reports due",
                     $realtime, quiet_cycles, due_reports.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        set_idling(20, 52);
        test_keymap_load();
        test_directed_cases();
        test_random_phase(DEBOUNCE_RESET, 125);
        test_random_phase(8'hFF, 125);

        // the other way round
        set_idling(52, 20);
        test_random_phase(HIST_W'($urandom_range(1, 255)), 125);
        test_random_phase(8'h01, 125);

        // no idling on either side
        set_idling(0, 0);
        test_random_phase(8'h80, 125);
        test_backpressure();
        test_random_phase(HIST_W'($urandom_range(1, 255)), 125);

        settle_block();
        $display("Covered %0d items and %0d reports: keymap load, slot overflow, layer keys,",
                 items_sent, reports_checked);
        $display("dropped writes, debounce masks from 0x00 to 0xFF and a long output hold-off.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== keyboard_scan_layer_report.f =====
+incdir+hw/rtl
hw/rtl/kslr_pkg.sv
hw/rtl/kslr_keystate.sv
hw/rtl/kslr_keymap.sv
hw/rtl/kslr_report.sv
hw/rtl/keyboard_scan_layer_report.sv
hw/rtl/kslr_checker.sv
sim/tb_keyboard_scan_layer_report.sv
